@@ design/csas_pkg.sv @@
// Shared types, constants and class helpers for the classful subnet split block.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package csas_pkg;

    // table size and widths
    localparam int NUM_ENTRIES   = 8;
    localparam int CELL_IDX_W    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ENTRY_INDEX_W = 3;
    localparam int WORD_W        = 32;

    // opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MAKE  = 2'd1;
    localparam logic [1:0] OP_NETOF = 2'd2;
    localparam logic [1:0] OP_HOSTOF = 2'd3;

    // classful masks
    localparam logic [WORD_W-1:0] CLASS_A_NET  = 32'hFF00_0000;
    localparam logic [WORD_W-1:0] CLASS_A_HOST = 32'h00FF_FFFF;
    localparam logic [WORD_W-1:0] CLASS_B_NET  = 32'hFFFF_0000;
    localparam logic [WORD_W-1:0] CLASS_B_HOST = 32'h0000_FFFF;
    localparam logic [WORD_W-1:0] CLASS_C_NET  = 32'hFFFF_FF00;
    localparam logic [WORD_W-1:0] CLASS_C_HOST = 32'h0000_00FF;

    // one request beat as it travels down the cell chain
    typedef struct packed {
        logic [1:0]               opcode;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic                     entry_valid;
        logic [WORD_W-1:0]        entry_netmask;
        logic [WORD_W-1:0]        entry_network;
        logic [WORD_W-1:0]        entry_subnetmask;
        logic [WORD_W-1:0]        address;
        logic [WORD_W-1:0]        host;
        logic [WORD_W-1:0]        key;
        logic                     hit;
        logic [WORD_W-1:0]        submask;
    } t_item;

    // class network mask of an address (D and E fold into C)
    function automatic logic [WORD_W-1:0] class_netmask(input logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] m;
        if (!a[31]) begin
            m = CLASS_A_NET;
        end else if (!a[30]) begin
            m = CLASS_B_NET;
        end else begin
            m = CLASS_C_NET;
        end
        return m;
    endfunction

    // class host mask of an address
    function automatic logic [WORD_W-1:0] class_hostmask(input logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] m;
        if (!a[31]) begin
            m = CLASS_A_HOST;
        end else if (!a[30]) begin
            m = CLASS_B_HOST;
        end else begin
            m = CLASS_C_HOST;
        end
        return m;
    endfunction

endpackage

@@ design/csas_cell.sv @@
// One cell of the lookup chain: holds one table entry and one stage of the request flow.
// Depends on csas_pkg for the beat type and opcodes.
`timescale 1ns / 1ps

module csas_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [csas_pkg::CELL_IDX_W-1:0]     i_cell_idx,
    input  logic                                i_load,
    input  logic                                i_valid,
    input  csas_pkg::t_item                     i_item,
    output logic                                o_valid,
    output csas_pkg::t_item                     o_item
);

    logic                         r_ent_valid;
    logic [csas_pkg::WORD_W-1:0]  r_ent_netmask;
    logic [csas_pkg::WORD_W-1:0]  r_ent_net;
    logic [csas_pkg::WORD_W-1:0]  r_ent_submask;
    logic                         r_valid;
    csas_pkg::t_item              r_item;
    csas_pkg::t_item              n_item;
    logic                         w_is_write;
    logic                         w_write_here;
    logic                         w_match;

    // decode the incoming beat against this cell's entry
    assign w_is_write   = (i_item.opcode == csas_pkg::OP_WRITE);
    assign w_write_here = i_load && i_valid && w_is_write &&
                          (32'(i_item.entry_index) == 32'(i_cell_idx));
    assign w_match      = r_ent_valid && ((r_ent_netmask & i_item.key) == r_ent_net);

    // take the first match only
    always_comb begin
        n_item = i_item;
        if (!w_is_write && !i_item.hit && w_match) begin
            n_item.hit     = 1'b1;
            n_item.submask = r_ent_submask;
        end
    end

    // control: stage valid and entry valid mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_ent_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid <= i_valid;
            end
            if (w_write_here) begin
                r_ent_valid <= i_item.entry_valid;
            end
        end
    end

    // payload: stage beat and entry fields
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
        if (w_write_here) begin
            r_ent_netmask <= i_item.entry_netmask;
            r_ent_net     <= i_item.entry_network;
            r_ent_submask <= i_item.entry_subnetmask;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // a write beat never leaves with a hit
    a_write_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_valid && w_is_write) |=> !o_item.hit)
        else $error("csas_cell: write beat carries a hit");

    // a hit found upstream is kept
    a_hit_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_valid && i_item.hit) |=> (o_item.hit && o_item.submask == $past(i_item.submask)))
        else $error("csas_cell: upstream hit lost or overwritten");

endmodule

@@ design/csas_result.sv @@
// Output stage: forms the result word from the beat leaving the chain and holds it.
// Depends on csas_pkg for the beat type, opcodes and class helpers.
`timescale 1ns / 1ps

module csas_result (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  csas_pkg::t_item               i_item,
    input  logic                          i_out_stall,
    output logic                          o_go,
    output logic                          o_valid,
    output logic [csas_pkg::WORD_W-1:0]   o_result_value,
    output logic                          o_subnet_hit
);

    logic                         r_valid;
    logic [csas_pkg::WORD_W-1:0]  r_value;
    logic                         r_hit;
    logic [csas_pkg::WORD_W-1:0]  n_value;
    logic                         n_hit;
    logic [csas_pkg::WORD_W-1:0]  w_netm;
    logic [csas_pkg::WORD_W-1:0]  w_hostm;
    logic [csas_pkg::WORD_W-1:0]  w_hpart;

    // advance when the register is empty or being taken
    assign o_go = !r_valid || !i_out_stall;

    assign w_netm  = csas_pkg::class_netmask(i_item.address);
    assign w_hostm = csas_pkg::class_hostmask(i_item.address);
    assign w_hpart = i_item.address & w_hostm;

    // build the result per opcode
    always_comb begin
        n_hit = i_item.hit;
        unique case (i_item.opcode)
            csas_pkg::OP_WRITE: begin
                n_value = '0;
                n_hit   = 1'b0;
            end
            csas_pkg::OP_MAKE: begin
                n_value = i_item.address |
                          (i_item.host & (i_item.hit ? ~i_item.submask : w_hostm));
            end
            csas_pkg::OP_NETOF: begin
                n_value = i_item.hit ? (i_item.address & i_item.submask)
                                     : (i_item.address & w_netm);
            end
            csas_pkg::OP_HOSTOF: begin
                n_value = i_item.hit ? (w_hpart & ~i_item.submask) : w_hpart;
            end
            default: begin
                n_value = '0;
                n_hit   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_go) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_go) begin
            r_value <= n_value;
            r_hit   <= n_hit;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_value;
    assign o_subnet_hit   = r_hit;

    // a beat offered while the stage advances shows up next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_go) |=> o_valid)
        else $error("csas_result: beat lost at output stage");

endmodule

@@ design/classful_subnet_address_split_core.sv @@
// Top level of the classful subnet split: a chain of table cells and an output stage.
// Depends on csas_pkg, csas_cell and csas_result.
// Throughput: one beat per cycle while i_out_stall is low; each cell holds one table
// entry and one request stage. Bubbles in the chain close up, so input is still taken
// while a result waits to be taken, as long as some cell of the chain is empty.
// Reset clears all entry valid marks and stage valids; entry contents stay undefined.
`timescale 1ns / 1ps

module classful_subnet_address_split_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_opcode,
    input  logic [csas_pkg::ENTRY_INDEX_W-1:0]  i_entry_index,
    input  logic                                i_entry_valid,
    input  logic [csas_pkg::WORD_W-1:0]         i_entry_netmask,
    input  logic [csas_pkg::WORD_W-1:0]         i_entry_network,
    input  logic [csas_pkg::WORD_W-1:0]         i_entry_subnetmask,
    input  logic [csas_pkg::WORD_W-1:0]         i_address_in,
    input  logic [csas_pkg::WORD_W-1:0]         i_host_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [csas_pkg::WORD_W-1:0]         o_result_value,
    output logic                                o_subnet_hit
);

    csas_pkg::t_item                       w_in_item;
    csas_pkg::t_item                       w_item [csas_pkg::NUM_ENTRIES];
    logic [csas_pkg::NUM_ENTRIES-1:0]      w_v;
    logic [csas_pkg::NUM_ENTRIES:0]        w_go;

    // pack the input beat; search key is the address for make, else its class network
    always_comb begin
        w_in_item.opcode           = i_opcode;
        w_in_item.entry_index      = i_entry_index;
        w_in_item.entry_valid      = i_entry_valid;
        w_in_item.entry_netmask    = i_entry_netmask;
        w_in_item.entry_network    = i_entry_network;
        w_in_item.entry_subnetmask = i_entry_subnetmask;
        w_in_item.address          = i_address_in;
        w_in_item.host             = i_host_in;
        w_in_item.key              = (i_opcode == csas_pkg::OP_MAKE) ? i_address_in :
                                     (i_address_in & csas_pkg::class_netmask(i_address_in));
        w_in_item.hit              = 1'b0;
        w_in_item.submask          = '0;
    end

    // a stage advances when empty or when the next one advances
    genvar k;
    generate
        for (k = 0; k < csas_pkg::NUM_ENTRIES; k++) begin : g_cell
            assign w_go[k] = !w_v[k] || w_go[k+1];

            if (k == 0) begin : g_head
                csas_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_cell_idx (csas_pkg::CELL_IDX_W'(k)),
                    .i_load     (w_go[k]),
                    .i_valid    (i_in_valid),
                    .i_item     (w_in_item),
                    .o_valid    (w_v[k]),
                    .o_item     (w_item[k])
                );
            end else begin : g_body
                csas_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_cell_idx (csas_pkg::CELL_IDX_W'(k)),
                    .i_load     (w_go[k]),
                    .i_valid    (w_v[k-1]),
                    .i_item     (w_item[k-1]),
                    .o_valid    (w_v[k]),
                    .o_item     (w_item[k])
                );
            end
        end
    endgenerate

    // form and hold the result
    csas_result u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_v[csas_pkg::NUM_ENTRIES-1]),
        .i_item         (w_item[csas_pkg::NUM_ENTRIES-1]),
        .i_out_stall    (i_out_stall),
        .o_go           (w_go[csas_pkg::NUM_ENTRIES]),
        .o_valid        (o_out_valid),
        .o_result_value (o_result_value),
        .o_subnet_hit   (o_subnet_hit)
    );

    assign o_in_stall = !w_go[0];

    // an accepted beat lands in the first cell
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_v[0])
        else $error("classful_subnet_address_split_core: accepted beat dropped");

endmodule
